[sv/atl_pkg.sv]
// ----------------------------------------------------------------------------
// atl_pkg: shared types and constants of the ASID translation buffer
// Sizes, field widths, page arithmetic helpers, command and status codes.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int ENTRIES     = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int LEVEL_SHIFT = 9;
  localparam int VA_W        = 48;
  localparam int PA_W        = 64;
  localparam int ASID_W      = 16;
  localparam int PERM_W      = 4;
  localparam int STAMP_W     = 32;
  localparam int VPN_W       = VA_W - PAGE_SHIFT;
  localparam int PPN_W       = PA_W - PAGE_SHIFT;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W       = $clog2(ENTRIES + 1);
  localparam int PERM_LARGE  = 3;
  localparam int IN_DATA_W   = ((VA_W + ASID_W + PERM_W + PA_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_HIT   = 2'd0,
    STS_MISS  = 2'd1,
    STS_FAULT = 2'd2,
    STS_DONE  = 2'd3
  } sts_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MATCH, ST_EXEC, ST_READ, ST_EVICT, ST_FLUSH, ST_RESP
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } match_t;

  typedef logic [ENTRIES-1:0]             vld_vec_t;
  typedef logic [ENTRIES-1:0][ASID_W-1:0] asid_arr_t;
  typedef logic [ENTRIES-1:0][VPN_W-1:0]  vpn_arr_t;

  // Virtual page number, aligned down to a large page when asked.
  function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                              input logic big);
    logic [VPN_W-1:0] v;
    v = va[VA_W-1:PAGE_SHIFT];
    if (big) v[LEVEL_SHIFT-1:0] = '0;
    return v;
  endfunction

  function automatic logic [PPN_W-1:0] ppn_of(input logic [PA_W-1:0] pa,
                                              input logic big);
    logic [PPN_W-1:0] p;
    p = pa[PA_W-1:PAGE_SHIFT];
    if (big) p[LEVEL_SHIFT-1:0] = '0;
    return p;
  endfunction

  function automatic logic [PA_W-1:0] offset_of(input logic [VA_W-1:0] va,
                                                input logic big);
    logic [PA_W-1:0] o;
    o = '0;
    o[PAGE_SHIFT-1:0] = va[PAGE_SHIFT-1:0];
    if (big) o[PAGE_SHIFT+LEVEL_SHIFT-1:PAGE_SHIFT] =
      va[PAGE_SHIFT+LEVEL_SHIFT-1:PAGE_SHIFT];
    return o;
  endfunction

endpackage

[sv/atl_match.sv]
// ----------------------------------------------------------------------------
// atl_match: associative tag compare
// Compares all tags at once; small pages win over large, lowest index first.
// Result registered.
// ----------------------------------------------------------------------------
module atl_match import atl_pkg::*; (
  input  logic             clk,
  input  vld_vec_t         valid,
  input  vld_vec_t         big,
  input  asid_arr_t        tag_asid,
  input  vpn_arr_t         tag_vpn,
  input  logic [ASID_W-1:0] key_asid,
  input  logic [VPN_W-1:0]  key_vpn,
  output match_t           res
);

  vld_vec_t hit_small;
  vld_vec_t hit_large;
  match_t   res_next;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      logic [VPN_W-1:0] diff;
      diff = tag_vpn[i] ^ key_vpn;
      if (big[i]) diff[LEVEL_SHIFT-1:0] = '0;
      hit_small[i] = valid[i] && (tag_asid[i] == key_asid) && (diff == '0) && !big[i];
      hit_large[i] = valid[i] && (tag_asid[i] == key_asid) && (diff == '0) && big[i];
    end
  end

  // priority pick: scan downward so the lowest index is written last
  always_comb begin
    res_next = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_large[i]) begin
        res_next.hit = 1'b1;
        res_next.idx = IDX_W'(i);
      end
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (hit_small[i]) begin
        res_next.hit = 1'b1;
        res_next.idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

[sv/asid_tlb_lru_core.sv]
// ----------------------------------------------------------------------------
// asid_tlb_lru_core: fully associative ASID-tagged translation buffer
// Lookup, insert with LRU eviction, remove and flush over 32 slots.
// ----------------------------------------------------------------------------
// Sequence: every command passes match and execute before the response;
//   a lookup hit adds a payload read, an insert that must evict a scan of
//   all slots, a flush a walk over all slots.
// Throughput: one item at a time; the next input is taken once the previous
//   result sits in the output register. Eviction length is set by the scan
//   of the stamp memory, one entry per cycle; flush by the per-slot walk.
// Reset: synchronous; clears valid bits, stamps, recency counter and output,
//   and loads the free stack with 0..ENTRIES-1. No clearing pass.
// ----------------------------------------------------------------------------
module asid_tlb_lru_core import atl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: virt_addr[47:0], asid[63:48], perm_bits[67:64],
  //          phys_addr_in[131:68], zero pad[135:132]
  input  logic [IN_DATA_W-1:0] s_tdata,
  // s_tuser: kind
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: phys_addr_out
  output logic [PA_W-1:0]      m_tdata,
  // m_tuser: status
  output logic [1:0]           m_tuser
);

  state_t state, state_next;

  // held command
  cmd_t              kind;
  logic [VA_W-1:0]   virt;
  logic [ASID_W-1:0] asid;
  logic [PERM_W-1:0] perm;
  logic [PA_W-1:0]   phys;

  // tag side in flops so every slot can be compared at once
  vld_vec_t          valid;
  vld_vec_t          stamp_set;   // stamp written since reset, else reads zero
  asid_arr_t         tag_asid;
  vpn_arr_t          tag_vpn;
  logic [PERM_W-1:0] tag_perm [ENTRIES];
  vld_vec_t          big;

  // payload and stamps in memories, registered read
  logic [PPN_W-1:0]   ppn_mem   [ENTRIES];
  logic [STAMP_W-1:0] stamp_mem [ENTRIES];
  logic [PPN_W-1:0]   ppn_rd;
  logic [STAMP_W-1:0] stamp_rd;
  logic [IDX_W-1:0]   stamp_raddr;

  logic [IDX_W-1:0]   free_stack [ENTRIES];
  logic [CNT_W-1:0]   free_count;
  logic [STAMP_W-1:0] recency;

  // eviction / flush walk
  logic [CNT_W-1:0]   scan;
  logic [IDX_W-1:0]   best;
  logic [STAMP_W-1:0] best_stamp;
  logic               found;
  logic [IDX_W-1:0]   prev;
  logic [STAMP_W-1:0] prev_stamp;
  logic               take_prev;
  logic [IDX_W-1:0]   cand_best;
  logic               cand_found;

  logic               hit_large;
  sts_t               res_status;
  logic [PA_W-1:0]    res_addr;
  logic               out_free;
  match_t             mres;
  logic [IDX_W-1:0]   top;
  logic [IDX_W-1:0]   pop_idx;    // slot index on top of the free stack

  for (genvar g = 0; g < ENTRIES; g++) begin : g_large
    assign big[g] = tag_perm[g][PERM_LARGE];
  end

  atl_match u_match (
    .clk      (clk),
    .valid    (valid),
    .big      (big),
    .tag_asid (tag_asid),
    .tag_vpn  (tag_vpn),
    .key_asid (asid),
    .key_vpn  (virt[VA_W-1:PAGE_SHIFT]),
    .res      (mres)
  );

  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == ST_IDLE);
  assign stamp_raddr = scan[IDX_W-1:0];
  assign top         = IDX_W'(free_count - CNT_W'(1));
  assign pop_idx     = free_stack[top];

  // eviction compare on the stamp read issued last cycle
  always_comb begin
    prev       = IDX_W'(scan - CNT_W'(1));
    prev_stamp = stamp_set[prev] ? stamp_rd : '0;
    take_prev  = (scan != '0) && valid[prev] && (!found || prev_stamp < best_stamp);
    cand_best  = take_prev ? prev : best;
    cand_found = found || take_prev;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (s_tvalid) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_EXEC;
      ST_EXEC: begin
        state_next = ST_RESP;
        if (kind == CMD_LOOKUP && mres.hit &&
            ((tag_perm[mres.idx] & perm) == perm)) state_next = ST_READ;
        if (kind == CMD_INSERT && perm != '0 && !mres.hit && free_count == '0)
          state_next = ST_EVICT;
        if (kind == CMD_FLUSH) state_next = ST_FLUSH;
      end
      ST_READ:  state_next = ST_RESP;
      ST_EVICT: if (scan == CNT_W'(ENTRIES)) state_next = ST_RESP;
      ST_FLUSH: if (scan == CNT_W'(ENTRIES - 1)) state_next = ST_RESP;
      ST_RESP:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // memory ports
  always_ff @(posedge clk) begin
    ppn_rd   <= ppn_mem[mres.idx];
    stamp_rd <= stamp_mem[stamp_raddr];
    if (state == ST_EXEC && kind == CMD_LOOKUP && mres.hit &&
        ((tag_perm[mres.idx] & perm) == perm))
      stamp_mem[mres.idx] <= recency + STAMP_W'(1);
    if (state == ST_EXEC && kind == CMD_INSERT && perm != '0) begin
      if (mres.hit)
        ppn_mem[mres.idx] <= ppn_of(phys, perm[PERM_LARGE]);
      else if (free_count != '0)
        ppn_mem[pop_idx] <= ppn_of(phys, perm[PERM_LARGE]);
    end
    if (state == ST_EVICT && scan == CNT_W'(ENTRIES) && cand_found)
      ppn_mem[cand_best] <= ppn_of(phys, perm[PERM_LARGE]);
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      kind <= cmd_t'(s_tuser);
      virt <= s_tdata[VA_W-1:0];
      asid <= s_tdata[VA_W+ASID_W-1:VA_W];
      perm <= s_tdata[VA_W+ASID_W+PERM_W-1:VA_W+ASID_W];
      phys <= s_tdata[VA_W+ASID_W+PERM_W+PA_W-1:VA_W+ASID_W+PERM_W];
    end
    if (state == ST_EXEC) hit_large <= big[mres.idx];
    if (state == ST_EXEC && kind == CMD_INSERT && perm != '0) begin
      if (mres.hit) begin
        tag_perm[mres.idx] <= perm;
        if (big[mres.idx] != perm[PERM_LARGE]) begin
          tag_asid[mres.idx] <= asid;
          tag_vpn[mres.idx]  <= vpn_of(virt, perm[PERM_LARGE]);
        end
      end else if (free_count != '0) begin
        tag_perm[pop_idx] <= perm;
        tag_asid[pop_idx] <= asid;
        tag_vpn[pop_idx]  <= vpn_of(virt, perm[PERM_LARGE]);
      end
    end
    if (state == ST_EVICT && scan == CNT_W'(ENTRIES) && cand_found) begin
      tag_perm[cand_best] <= perm;
      tag_asid[cand_best] <= asid;
      tag_vpn[cand_best]  <= vpn_of(virt, perm[PERM_LARGE]);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      stamp_set  <= '0;
      recency    <= '0;
      free_count <= CNT_W'(ENTRIES);
      for (int i = 0; i < ENTRIES; i++) free_stack[i] <= IDX_W'(i);
      scan       <= '0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      // a new result loaded in ST_RESP takes precedence over the drain
      if (m_tready && !(state == ST_RESP && out_free)) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          scan  <= '0;
          found <= 1'b0;
        end
        ST_EXEC: begin
          res_addr <= '0;
          case (kind)
            CMD_LOOKUP: begin
              if (!mres.hit) begin
                res_status <= STS_MISS;
              end else if ((tag_perm[mres.idx] & perm) != perm) begin
                res_status <= STS_FAULT;
              end else begin
                res_status           <= STS_HIT;
                recency              <= recency + STAMP_W'(1);
                stamp_set[mres.idx]  <= 1'b1;
              end
            end
            CMD_INSERT: begin
              res_status <= STS_DONE;
              if (perm != '0 && !mres.hit && free_count != '0) begin
                free_count     <= free_count - CNT_W'(1);
                valid[pop_idx] <= 1'b1;
              end
            end
            CMD_REMOVE: begin
              res_status <= STS_DONE;
              if (mres.hit) begin
                valid[mres.idx] <= 1'b0;
                if (free_count < CNT_W'(ENTRIES)) begin
                  free_stack[free_count[IDX_W-1:0]] <= mres.idx;
                  free_count <= free_count + CNT_W'(1);
                end
              end
            end
            default: res_status <= STS_DONE;
          endcase
        end
        ST_READ: res_addr <= {ppn_rd, {PAGE_SHIFT{1'b0}}} + offset_of(virt, hit_large);
        ST_EVICT: begin
          // slot is freed and popped again at once: stays valid, stack unchanged
          scan       <= scan + CNT_W'(1);
          best       <= cand_best;
          found      <= cand_found;
          if (take_prev) best_stamp <= prev_stamp;
        end
        ST_FLUSH: begin
          scan <= scan + CNT_W'(1);
          if (valid[scan[IDX_W-1:0]]) begin
            valid[scan[IDX_W-1:0]] <= 1'b0;
            if (free_count < CNT_W'(ENTRIES)) begin
              free_stack[free_count[IDX_W-1:0]] <= scan[IDX_W-1:0];
              free_count <= free_count + CNT_W'(1);
            end
          end
        end
        ST_RESP: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= res_addr;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[sv/atl_checker.sv]
// ----------------------------------------------------------------------------
// atl_checker: port-level checks of the translation buffer
// Output hold, zero address on non-hits, one item in flight, reset.
// ----------------------------------------------------------------------------
module atl_checker import atl_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [PA_W-1:0]      m_tdata,
  input logic [1:0]           m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != STS_HIT |-> m_tdata == '0)
    else $error("non-hit result carries an address");

  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready && !(m_tvalid && $rose(m_tvalid)))
    else $error("second item taken or early result");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind asid_tlb_lru_core atl_checker u_atl_checker (.*);

[bench/asid_tlb_lru_core_tb.sv]
// ----------------------------------------------------------------------------
// asid_tlb_lru_core_tb: self-checking bench of the ASID translation buffer
// Drives lookups, inserts, removes and flushes through the stream ports,
// predicts each status and translated address, compares in order.
// ----------------------------------------------------------------------------
module asid_tlb_lru_core_tb;
  import atl_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // s_tdata: virt_addr, asid, perm_bits, phys_addr_in, zero pad (low bit up)
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // s_tuser: kind
  logic [1:0]           s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // m_tdata: phys_addr_out
  logic [PA_W-1:0]      m_tdata;
  // m_tuser: status
  logic [1:0]           m_tuser;

  asid_tlb_lru_core DUT (.*);

  always #10 clk = ~clk;

  // ---- translation predictor state ----
  logic              tv_valid [ENTRIES];
  logic [ASID_W-1:0] tv_asid  [ENTRIES];
  logic [VPN_W-1:0]  tv_vpn   [ENTRIES];
  logic [PPN_W-1:0]  tv_ppn   [ENTRIES];
  logic [PERM_W-1:0] tv_perm  [ENTRIES];
  logic [31:0]       tv_stamp [ENTRIES];
  logic [31:0]       recency;
  int                free_idx [ENTRIES];
  int                free_cnt;

  typedef struct packed {
    sts_t            status;
    logic [PA_W-1:0] pa;
  } xlat_t;

  xlat_t       pending_xlat[$];
  int          errors = 0;
  longint      cycles = 0;
  bit          hold_off = 1'b0;   // long receiver stall request
  bit          tx_gaps = 1'b1;    // sender bursts on/off
  localparam longint LIMIT = 2_000_000;

  // Pool of addresses so that lookups hit stored mappings often.
  logic [ASID_W-1:0] pool_asid [8];
  logic [VA_W-1:0]   pool_va   [8];

  function automatic int find_mapping(logic [ASID_W-1:0] a, logic [VA_W-1:0] va);
    int large_hit;
    logic [VPN_W-1:0] vp, msk;
    large_hit = -1;
    vp = va[VA_W-1:PAGE_SHIFT];
    for (int i = 0; i < ENTRIES; i++) begin
      msk = tv_perm[i][PERM_LARGE] ? ~((VPN_W'(1) << LEVEL_SHIFT) - 1) : '1;
      if (tv_valid[i] && tv_asid[i] == a && ((tv_vpn[i] ^ vp) & msk) == '0) begin
        if (!tv_perm[i][PERM_LARGE]) return i;
        if (large_hit < 0) large_hit = i;
      end
    end
    return large_hit;
  endfunction

  function automatic void release_slot(int i);
    tv_valid[i] = 1'b0;
    if (free_cnt < ENTRIES) begin
      free_idx[free_cnt] = i;
      free_cnt++;
    end
  endfunction

  function automatic void tag_mapping(int i, logic [ASID_W-1:0] a,
                                      logic [VA_W-1:0] va, logic big);
    tv_asid[i] = a;
    tv_vpn[i]  = va[VA_W-1:PAGE_SHIFT];
    if (big) tv_vpn[i][LEVEL_SHIFT-1:0] = '0;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < ENTRIES; i++) begin
      tv_valid[i] = 0; tv_asid[i] = 0; tv_vpn[i] = 0; tv_ppn[i] = 0;
      tv_perm[i] = 0; tv_stamp[i] = 0; free_idx[i] = i;
    end
    recency = 0;
    free_cnt = ENTRIES;
  endfunction

  function automatic xlat_t predict_xlat(cmd_t k, logic [VA_W-1:0] va,
                                         logic [ASID_W-1:0] a,
                                         logic [PERM_W-1:0] p,
                                         logic [PA_W-1:0] pa);
    xlat_t r;
    int s, best;
    logic big;
    logic [PA_W-1:0] omask;
    r.status = STS_DONE;
    r.pa = '0;
    case (k)
      CMD_LOOKUP: begin
        s = find_mapping(a, va);
        if (s < 0) r.status = STS_MISS;
        else if ((tv_perm[s] & p) != p) r.status = STS_FAULT;
        else begin
          recency++;
          tv_stamp[s] = recency;
          omask = tv_perm[s][PERM_LARGE] ? (64'd1 << (PAGE_SHIFT + LEVEL_SHIFT)) - 1
                                        : (64'd1 << PAGE_SHIFT) - 1;
          r.pa = ({12'd0, tv_ppn[s]} << PAGE_SHIFT) + ({16'd0, va} & omask);
          r.status = STS_HIT;
        end
      end
      CMD_INSERT: begin
        if (p != 0) begin
          big = p[PERM_LARGE];
          s = find_mapping(a, va);
          if (s < 0) begin
            if (free_cnt == 0) begin
              best = -1;
              for (int i = 0; i < ENTRIES; i++)
                if (tv_valid[i] && (best < 0 || tv_stamp[i] < tv_stamp[best])) best = i;
              if (best >= 0) release_slot(best);
            end
            if (free_cnt > 0) begin
              free_cnt--;
              s = free_idx[free_cnt] % ENTRIES;
              tv_valid[s] = 1'b1;
              tag_mapping(s, a, va, big);
            end
          end else if (tv_perm[s][PERM_LARGE] != big) begin
            tag_mapping(s, a, va, big);
          end
          if (s >= 0) begin
            tv_ppn[s] = pa[PA_W-1:PAGE_SHIFT];
            if (big) tv_ppn[s][LEVEL_SHIFT-1:0] = '0;
            tv_perm[s] = p;
          end
        end
      end
      CMD_REMOVE: begin
        s = find_mapping(a, va);
        if (s >= 0) release_slot(s);
      end
      default: begin
        for (int i = 0; i < ENTRIES; i++)
          if (tv_valid[i]) release_slot(i);
      end
    endcase
    return r;
  endfunction

  // ---- sender ----
  task automatic send_item(cmd_t k, logic [VA_W-1:0] va, logic [ASID_W-1:0] a,
                           logic [PERM_W-1:0] p, logic [PA_W-1:0] pa);
    xlat_t exp_x;
    exp_x = predict_xlat(k, va, a, p, pa);
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {4'b0, pa, p, a, va};
    pending_xlat = {pending_xlat, exp_x};
    do @(posedge clk); while (!s_tready);
    // bursts: occasionally drop valid after a transfer
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (3 + ENTRIES + 4) @(posedge clk);
  endtask

  function automatic logic [VA_W-1:0] rand_va();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [PA_W-1:0] rand_pa();
    return {$urandom(), $urandom()};
  endfunction

  // ---- receiver: own stall pattern plus long hold-off ----
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_off) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 9) < 7) || (cycles % 200 < 40);
  end

  // ---- result checker ----
  always @(posedge clk) begin
    xlat_t want;
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_xlat.size() == 0) begin
        $error("unexpected result transfer status=%0d pa=%h", m_tuser, m_tdata);
        errors++;
      end else begin
        want = pending_xlat.pop_front();
        if (m_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tuser);
          errors++;
        end
        if (m_tdata !== want.pa) begin
          $error("phys_addr_out: expected %h, actual %h", want.pa, m_tdata);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("[asid_tlb_lru_core] ERROR");
      $finish;
    end
  end

  // ---- test tasks ----
  task automatic test_directed();
    // empty buffer: miss, remove absent, flush, null insert
    send_item(CMD_LOOKUP, '0, '0, '0, '0);
    send_item(CMD_REMOVE, '1, '1, '1, '0);
    send_item(CMD_FLUSH, '1, '1, '1, '1);
    send_item(CMD_INSERT, 48'h1000, 16'h1, 4'h0, 64'hABC000);
    send_item(CMD_LOOKUP, 48'h1000, 16'h1, 4'h0, '0);
    // small page, extremes
    send_item(CMD_INSERT, '1, '1, 4'h7, '1);
    send_item(CMD_LOOKUP, '1, '1, 4'h7, '0);
    send_item(CMD_LOOKUP, '1, '1, 4'hF, '0);      // fault on large bit
    send_item(CMD_LOOKUP, '1, 16'hFFFE, 4'h1, '0); // asid mismatch
    // large page and small overlap: small wins
    send_item(CMD_INSERT, 48'h0000_4020_0000, 16'h5, 4'h9, 64'hFFFF_0000_0055_5000);
    send_item(CMD_LOOKUP, 48'h0000_4021_2345, 16'h5, 4'h8, '0);
    send_item(CMD_INSERT, 48'h0000_4021_2000, 16'h5, 4'h3, 64'h7000);
    send_item(CMD_LOOKUP, 48'h0000_4021_2345, 16'h5, 4'h1, '0);
    send_item(CMD_LOOKUP, 48'h0000_4021_2345, 16'h5, 4'h4, '0);
    // resize existing small to large, update same size
    send_item(CMD_INSERT, 48'h0000_4021_2abc, 16'h5, 4'hC, 64'h1234_5678_9abc_def0);
    send_item(CMD_INSERT, 48'h0000_4021_2abc, 16'h5, 4'hF, 64'h0000_0000_0020_0000);
    send_item(CMD_LOOKUP, 48'h0000_4021_2abc, 16'h5, 4'hF, '0);
    send_item(CMD_REMOVE, 48'h0000_4021_2abc, 16'h5, 4'h0, '0);
    send_item(CMD_LOOKUP, 48'h0000_4021_2abc, 16'h5, 4'h0, '0);
    // fill beyond capacity to force evictions
    for (int i = 0; i < ENTRIES + 3; i++) begin
      send_item(CMD_INSERT, 48'(i) << PAGE_SHIFT, 16'h9, 4'h1, rand_pa());
      if (i % 3 == 0) send_item(CMD_LOOKUP, 48'(i) << PAGE_SHIFT, 16'h9, 4'h1, '0);
    end
    send_item(CMD_FLUSH, '0, '0, '0, '0);
    drain();
  endtask

  task automatic test_random(int n);
    int j;
    cmd_t k;
    logic [VA_W-1:0] va;
    logic [ASID_W-1:0] a;
    for (int i = 0; i < 8; i++) begin
      pool_asid[i] = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
      pool_va[i] = rand_va();
    end
    for (int i = 0; i < n; i++) begin
      j = $urandom_range(0, 99);
      k = j < 45 ? CMD_LOOKUP : j < 85 ? CMD_INSERT : j < 98 ? CMD_REMOVE : CMD_FLUSH;
      if ($urandom_range(0, 4) != 0) begin
        j = $urandom_range(0, 7);
        a = pool_asid[j];
        va = pool_va[j] ^ 48'($urandom_range(0, 3) << ($urandom_range(0, 1) ? 0 : 14));
      end else begin
        a = 16'($urandom);
        va = rand_va();
      end
      send_item(k, va, a, 4'($urandom), rand_pa());
    end
    drain();
  endtask

  task automatic test_backpressure();
    // receiver holds off, sender keeps offering until input stalls
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        tx_gaps = 1'b0;
        for (int i = 0; i < 20; i++)
          send_item(cmd_t'($urandom_range(0, 1)), 48'(i) << PAGE_SHIFT, 16'h9,
                    4'($urandom), rand_pa());
        tx_gaps = 1'b1;
      end
    join
    drain();
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(320);
    test_backpressure();
    test_random(340);
    if (errors == 0) $display("[asid_tlb_lru_core] OK");
    else $display("[asid_tlb_lru_core] ERROR");
    $finish;
  end

endmodule
